// ----- hdl/assert_macros.svh -----
// Assertion helpers; the including module provides aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge out of reset.
`define GDE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define GDE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

`endif

// ----- hdl/gde_pkg.sv -----
package gde_pkg;

    localparam int DEFAULT_MAX_ROWS = 16;
    localparam int DEFAULT_MAX_COLS = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS      = 3'd0,
        REG_NUM_COLS      = 3'd1,
        REG_START_ROW     = 3'd2,
        REG_START_COL     = 3'd3,
        REG_START_HEADING = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ACT_TURN_LEFT  = 3'd0,
        ACT_TURN_RIGHT = 3'd1,
        ACT_FORWARD    = 3'd2,
        ACT_PICK_UP    = 3'd3,
        ACT_ASK_FREE   = 3'd4,
        ACT_ASK_MARKER = 3'd5,
        ACT_FINISHED   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_MARKER = 2'd1,
        PH_EXPLORE = 2'd2,
        PH_BACK   = 2'd3
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] row;
        logic [3:0] col;
    } nb_t;

    // Grid size in use: saturate to 1..lim.
    function automatic logic [4:0] clamp_size(input logic [4:0] v, input logic [4:0] lim);
        logic [4:0] r;
        r = v;
        if (r == 5'd0) r = 5'd1;
        if (r > lim) r = lim;
        return r;
    endfunction

    function automatic nb_t step_cell(input logic [3:0] row, input logic [3:0] col,
                                      input logic [1:0] dir, input logic [4:0] rows,
                                      input logic [4:0] cols);
        nb_t        n;
        logic [4:0] nr;
        logic [4:0] nc;
        logic       neg;
        nr  = {1'b0, row};
        nc  = {1'b0, col};
        neg = 1'b0;
        case (dir)
            DIR_UP: begin
                neg = (row == 4'd0);
                nr  = nr - 5'd1;
            end
            DIR_RIGHT: nc = nc + 5'd1;
            DIR_DOWN:  nr = nr + 5'd1;
            DIR_LEFT: begin
                neg = (col == 4'd0);
                nc  = nc - 5'd1;
            end
            default: neg = 1'b1;
        endcase
        n.ok  = !neg && (nr < rows) && (nc < cols);
        n.row = nr[3:0];
        n.col = nc[3:0];
        return n;
    endfunction

endpackage

// ----- hdl/grid_dfs_explorer.sv -----
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// s (req)   in         s_valid / s_ready      s_cmd, s_answer
// m (res)   out        m_valid / m_ready      m_action, m_pos_row, m_pos_col, m_heading, m_last
//
// One request at a time. A start request sweeps the visited RAM, one entry per cycle, then
// asks for a marker. A reply is accepted in S_IDLE; an in-bounds scanned direction reads the
// visited RAM (S_SCAN) and tests the registered bit (S_SCHK), an out-of-bounds one is skipped,
// an exhausted scan leaves via S_NONE, a backtrack reads the stack RAM (S_NONE, S_POP), each
// result has its own state, and the heading is checked (S_TURN) before the ask. Results leave
// through one output register; a stalled m_ready holds the sequencer at its next result.
// Reset (synchronous, aresetn low) clears control state; the RAMs keep their contents.
module grid_dfs_explorer #(
    parameter int MAX_ROW_COUNT = gde_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COL_COUNT = gde_pkg::DEFAULT_MAX_COLS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gde_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gde_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic                            s_answer,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_action,
    output logic [3:0]                      m_pos_row,
    output logic [3:0]                      m_pos_col,
    output logic [1:0]                      m_heading,
    output logic                            m_last
);
    import gde_pkg::*;

    `include "assert_macros.svh"

    localparam int Cells  = MAX_ROW_COUNT * MAX_COL_COUNT;
    localparam int CellW  = $clog2(Cells);
    localparam int StkW   = CellW + 1;
    localparam int RowLim = (MAX_ROW_COUNT < 16) ? MAX_ROW_COUNT : 16;
    localparam int ColLim = (MAX_COL_COUNT < 16) ? MAX_COL_COUNT : 16;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_MARK, S_PICK, S_SCAN, S_SCHK, S_NONE,
        S_POP, S_TURN, S_ASK, S_FWD
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      phase_reg, phase_next;
    logic [1:0]      scan_dir_reg, scan_dir_next;
    logic [2:0]      dir_reg, dir_next;
    logic [1:0]      want_reg, want_next;
    logic            back_reg, back_next;
    logic [3:0]      row_reg, row_next;
    logic [3:0]      col_reg, col_next;
    logic [1:0]      head_reg, head_next;
    logic [StkW-1:0] top_reg, top_next;
    logic [CellW-1:0] clr_reg, clr_next;

    logic [4:0] num_rows_reg, num_cols_reg;
    logic [3:0] start_row_reg, start_col_reg;
    logic [1:0] start_head_reg;

    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_action_reg, m_action_next;
    logic [3:0] m_row_reg, m_row_next;
    logic [3:0] m_col_reg, m_col_next;
    logic [1:0] m_head_reg, m_head_next;
    logic       m_last_reg, m_last_next;

    logic [4:0] eff_rows, eff_cols;
    logic       out_free;
    nb_t        scan_nb, head_nb;

    logic             vis_we, vis_wdata, vis_rdata;
    logic [CellW-1:0] vis_waddr, vis_raddr, cur_addr;
    logic             st_we;
    logic [7:0]       st_rdata;
    logic [CellW-1:0] st_raddr;

    logic [StkW-1:0] top_dec;
    logic [4:0]      pop_row, pop_col;
    logic [1:0]      head_diff;

    function automatic logic [CellW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
        return CellW'(32'(r) * 32'(MAX_COL_COUNT) + 32'(c));
    endfunction

    assign eff_rows = clamp_size(num_rows_reg, 5'(RowLim));
    assign eff_cols = clamp_size(num_cols_reg, 5'(ColLim));
    assign out_free = !m_valid_reg || m_ready;
    assign scan_nb  = step_cell(row_reg, col_reg, dir_reg[1:0], eff_rows, eff_cols);
    assign head_nb  = step_cell(row_reg, col_reg, head_reg, eff_rows, eff_cols);
    assign cur_addr = cell_addr(row_reg, col_reg);
    assign vis_raddr = cell_addr(scan_nb.row, scan_nb.col);
    assign top_dec  = top_reg - StkW'(1);
    assign st_raddr = top_dec[CellW-1:0];
    assign pop_row  = {1'b0, st_rdata[7:4]};
    assign pop_col  = {1'b0, st_rdata[3:0]};
    assign head_diff = want_reg - head_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    gde_ram #(.WIDTH(1), .DEPTH(Cells)) u_visited (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    gde_ram #(.WIDTH(8), .DEPTH(Cells)) u_stack (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (top_reg[CellW-1:0]),
        .wdata ({row_reg, col_reg}),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        scan_dir_next = scan_dir_reg;
        dir_next      = dir_reg;
        want_next     = want_reg;
        back_next     = back_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        head_next     = head_reg;
        top_next      = top_reg;
        clr_next      = clr_reg;
        vis_we        = 1'b0;
        vis_waddr     = cur_addr;
        vis_wdata     = 1'b1;
        st_we         = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_action_next = m_action_reg;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        m_head_next   = m_head_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (!s_cmd) begin
                        top_next      = '0;
                        scan_dir_next = 2'd0;
                        clr_next      = '0;
                        back_next     = 1'b0;
                        row_next = ({1'b0, start_row_reg} < eff_rows) ? start_row_reg
                                                                       : 4'(eff_rows - 5'd1);
                        col_next = ({1'b0, start_col_reg} < eff_cols) ? start_col_reg
                                                                       : 4'(eff_cols - 5'd1);
                        head_next  = start_head_reg;
                        state_next = S_CLEAR;
                    end else begin
                        case (phase_reg)
                            PH_MARKER: begin
                                dir_next   = 3'd0;
                                state_next = s_answer ? S_PICK : S_SCAN;
                            end
                            PH_EXPLORE: begin
                                dir_next = {1'b0, scan_dir_reg} + 3'd1;
                                if (s_answer && step_cell(row_reg, col_reg, scan_dir_reg,
                                                          eff_rows, eff_cols).ok) begin
                                    if (top_reg < StkW'(Cells)) begin
                                        st_we    = 1'b1;
                                        top_next = top_reg + StkW'(1);
                                    end
                                    row_next   = step_cell(row_reg, col_reg, scan_dir_reg,
                                                           eff_rows, eff_cols).row;
                                    col_next   = step_cell(row_reg, col_reg, scan_dir_reg,
                                                           eff_rows, eff_cols).col;
                                    state_next = S_FWD;
                                end else begin
                                    state_next = S_SCAN;
                                end
                            end
                            PH_BACK: begin
                                dir_next = 3'd0;
                                if (s_answer && head_nb.ok) begin
                                    row_next   = head_nb.row;
                                    col_next   = head_nb.col;
                                    state_next = S_FWD;
                                end else begin
                                    state_next = S_SCAN;
                                end
                            end
                            default: state_next = S_IDLE;
                        endcase
                    end
                end
            end
            S_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = 1'b0;
                clr_next  = clr_reg + CellW'(1);
                if (clr_reg == CellW'(Cells - 1)) begin
                    state_next = S_MARK;
                end
            end
            S_MARK: begin
                // a backtrack move does not mark the cell it lands on
                vis_we = !back_reg;
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_action_next = ACT_ASK_MARKER;
                    m_row_next    = row_reg;
                    m_col_next    = col_reg;
                    m_head_next   = head_reg;
                    m_last_next   = 1'b1;
                    phase_next    = PH_MARKER;
                    state_next    = S_IDLE;
                end
            end
            S_FWD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_action_next = ACT_FORWARD;
                    m_row_next    = row_reg;
                    m_col_next    = col_reg;
                    m_head_next   = head_reg;
                    m_last_next   = 1'b0;
                    state_next    = S_MARK;
                end
            end
            S_PICK: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_action_next = ACT_PICK_UP;
                    m_row_next    = row_reg;
                    m_col_next    = col_reg;
                    m_head_next   = head_reg;
                    m_last_next   = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (dir_reg[2]) begin
                    state_next = S_NONE;
                end else if (!scan_nb.ok) begin
                    dir_next = dir_reg + 3'd1;
                end else begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK: begin
                if (vis_rdata) begin
                    dir_next   = dir_reg + 3'd1;
                    state_next = S_SCAN;
                end else begin
                    scan_dir_next = dir_reg[1:0];
                    want_next     = dir_reg[1:0];
                    back_next     = 1'b0;
                    state_next    = S_TURN;
                end
            end
            S_NONE: begin
                if (top_reg == '0) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_action_next = ACT_FINISHED;
                        m_row_next    = row_reg;
                        m_col_next    = col_reg;
                        m_head_next   = head_reg;
                        m_last_next   = 1'b1;
                        phase_next    = PH_IDLE;
                        state_next    = S_IDLE;
                    end
                end else begin
                    top_next   = top_dec;
                    state_next = S_POP;
                end
            end
            S_POP: begin
                // left unless the target is exactly one step up, down or right
                if (pop_row + 5'd1 == {1'b0, row_reg} && pop_col == {1'b0, col_reg}) begin
                    want_next = DIR_UP;
                end else if (pop_row == {1'b0, row_reg} + 5'd1 &&
                             pop_col == {1'b0, col_reg}) begin
                    want_next = DIR_DOWN;
                end else if (pop_row == {1'b0, row_reg} &&
                             pop_col == {1'b0, col_reg} + 5'd1) begin
                    want_next = DIR_RIGHT;
                end else begin
                    want_next = DIR_LEFT;
                end
                back_next  = 1'b1;
                state_next = S_TURN;
            end
            S_TURN: begin
                if (head_diff == 2'd0) begin
                    state_next = S_ASK;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = row_reg;
                    m_col_next   = col_reg;
                    m_last_next  = 1'b0;
                    if (head_diff == 2'd3) begin
                        head_next     = head_reg - 2'd1;
                        m_action_next = ACT_TURN_LEFT;
                        m_head_next   = head_reg - 2'd1;
                    end else begin
                        head_next     = head_reg + 2'd1;
                        m_action_next = ACT_TURN_RIGHT;
                        m_head_next   = head_reg + 2'd1;
                    end
                end
            end
            S_ASK: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_action_next = ACT_ASK_FREE;
                    m_row_next    = row_reg;
                    m_col_next    = col_reg;
                    m_head_next   = head_reg;
                    m_last_next   = 1'b1;
                    phase_next    = back_reg ? PH_BACK : PH_EXPLORE;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            scan_dir_reg   <= 2'd0;
            dir_reg        <= 3'd0;
            want_reg       <= 2'd0;
            back_reg       <= 1'b0;
            row_reg        <= 4'd0;
            col_reg        <= 4'd0;
            head_reg       <= 2'd0;
            top_reg        <= '0;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
            num_rows_reg   <= 5'd16;
            num_cols_reg   <= 5'd16;
            start_row_reg  <= 4'd0;
            start_col_reg  <= 4'd0;
            start_head_reg <= 2'd0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            scan_dir_reg <= scan_dir_next;
            dir_reg      <= dir_next;
            want_reg     <= want_next;
            back_reg     <= back_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            head_reg     <= head_next;
            top_reg      <= top_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_NUM_ROWS:      num_rows_reg   <= cfg_data;
                    REG_NUM_COLS:      num_cols_reg   <= cfg_data;
                    REG_START_ROW:     start_row_reg  <= cfg_data[3:0];
                    REG_START_COL:     start_col_reg  <= cfg_data[3:0];
                    REG_START_HEADING: start_head_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
        m_action_reg <= m_action_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_head_reg   <= m_head_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_action  = m_action_reg;
    assign m_pos_row = m_row_reg;
    assign m_pos_col = m_col_reg;
    assign m_heading = m_head_reg;
    assign m_last    = m_last_reg;

    `GDE_ASSERT_ALWAYS(a_stack_bound, top_reg <= StkW'(Cells), "stack pointer past depth")
    `GDE_ASSERT_IMPL(a_chk_after_scan, state_reg == S_SCHK, $past(state_reg) == S_SCAN,
                     "visited check without a read issued")
    `GDE_ASSERT_IMPL(a_row_in_range, state_reg != S_IDLE || phase_reg != PH_IDLE,
                     32'(row_reg) < MAX_ROW_COUNT, "robot row outside grid")
    `GDE_ASSERT_IMPL(a_push_room, st_we, top_reg < StkW'(Cells), "push onto full stack")

endmodule

// ----- hdl/gde_ram.sv -----
module gde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
